// ===== design/bsts_pkg.sv =====
// Shared types and constants of the beam search top-k selector.
// No dependencies; bsts_cell, bsts_drain and the top level import this package.
package bsts_pkg;

   // Q16.16 extremes; the minimum stands for minus infinity.
   localparam logic [31:0] Q_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN_P1 = 32'h8000_0001;

   // Configuration register indexes.
   localparam logic [2:0] REG_BEAMS = 3'd0;
   localparam logic [2:0] REG_THRESH = 3'd1;
   localparam logic [2:0] REG_EOS_A = 3'd2;
   localparam logic [2:0] REG_EOS_B = 3'd3;
   localparam logic [2:0] REG_EOS_EN = 3'd4;

   // One candidate held by a cell of the sorted chain.
   typedef struct packed {
      logic        vld;
      logic [31:0] score;
      logic [3:0]  beam;
      logic [15:0] tok;
   } cand_type;

   // Per-cycle control that all cells share.
   typedef struct packed {
      logic take;      // an input beat is taken this cycle
      logic ins;       // insert the new candidate
      logic pre_clr;   // treat the chain as empty before the insert
      logic post_clr;  // empty the chain after this cycle
   } cell_ctl_type;

   // One result waiting in the drain.
   typedef struct packed {
      logic [3:0]  src;
      logic [15:0] tok;
      logic [31:0] score;
      logic        eos;
      logic        done;
   } out_ent_type;

endpackage

// ===== design/bsts_cell.sv =====
// One cell of the sorted candidate chain: keeps its entry, takes the new
// candidate, or takes its left neighbor's entry. Depends on bsts_pkg.
module bsts_cell import bsts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,         // this slot lies below the active beam count
   input  cell_ctl_type ctl,
   input  cand_type     new_cand,
   input  logic         left_keep,  // left neighbor keeps its own entry
   input  cand_type     left_cand,
   output logic         keep,
   output cand_type     cur,
   output cand_type     nxt
);

   cand_type cand_ff;
   cand_type cand_in;

   // Insert step: an equal score already held wins over the new arrival.
   // A slot beyond the beam count is dropped only when a beat is taken or the chain is emptied.
   always_comb begin
      cur = cand_ff;
      cur.vld = cand_ff.vld & en & ~ctl.pre_clr;
      keep = cur.vld && ($signed(cur.score) >= $signed(new_cand.score));
      nxt = cur;
      if (ctl.ins && !keep) begin
         if (left_keep) begin
            nxt = new_cand;
         end else begin
            nxt = left_cand;
         end
      end
      if (!en) begin
         nxt.vld = 1'b0;
      end
      cand_in = ctl.take ? nxt : cand_ff;
      if (ctl.post_clr) begin
         cand_in.vld = 1'b0;
      end
   end

   // The valid bit is control state; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.vld <= 1'b0;
      end else begin
         cand_ff.vld <= cand_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff.score <= cand_in.score;
      cand_ff.beam <= cand_in.beam;
      cand_ff.tok <= cand_in.tok;
   end

endmodule

// ===== design/bsts_drain.sv =====
// Output drain: a row of result stages that shifts one result out per beat.
// Depends on bsts_pkg.
module bsts_drain import bsts_pkg::*; #(
   parameter int MAX_BEAMS = 4,
   parameter int KW = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [KW-1:0] load_cnt,
   input  logic        load_all,
   input  out_ent_type load_ent [MAX_BEAMS],
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic        rsp_tlast,
   output out_ent_type head,
   output logic [3:0]  slot,
   output logic        every_done,
   output logic        free
);

   logic [KW-1:0] cnt_ff, cnt_in;
   logic [3:0]    slot_ff, slot_in;
   logic          all_ff, all_in;
   out_ent_type   ent_ff [MAX_BEAMS];
   logic          beat;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast = (cnt_ff == KW'(1));
   assign beat = rsp_tvalid && rsp_tready;
   assign free = (cnt_ff == '0) || (rsp_tlast && rsp_tready);
   assign head = ent_ff[0];
   assign slot = slot_ff;
   assign every_done = all_ff;

   // A new step loads over the last beat of the old one.
   always_comb begin
      cnt_in = cnt_ff;
      slot_in = slot_ff;
      all_in = all_ff;
      if (load) begin
         cnt_in = load_cnt;
         slot_in = '0;
         all_in = load_all;
      end else if (beat) begin
         cnt_in = cnt_ff - KW'(1);
         slot_in = slot_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         slot_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      all_ff <= all_in;
   end

   // Result stages shift toward the head on every beat.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_BEAMS; i++) begin
            ent_ff[i] <= load_ent[i];
         end
      end else if (beat) begin
         for (int i = 0; i < MAX_BEAMS - 1; i++) begin
            ent_ff[i] <= ent_ff[i + 1];
         end
      end
   end

endmodule

// ===== design/beam_search_topk_selector.sv =====
// Beam search top-k selector: per-beam score state, sorted candidate chain
// and output drain. Depends on bsts_pkg, bsts_cell and bsts_drain.
//
//  Channel | Direction | Carries
//  req_    | in        | one log-probability with beam and token per beat
//  rsp_    | out       | one slot result per beat, K beats per decoding step
//  csr_    | in        | register writes, no read-back
//
// An item is taken every cycle while req_tready is high; each beat that passes the
// beam and threshold checks inserts into the cell chain at once. A step-end beat
// hands the chain to the drain in the same cycle when the drain is empty or sends its
// last beat then; otherwise req_tready drops until it does. Results leave one per
// cycle, K per step, stalled by rsp_tready. Reset is synchronous; no clearing pass follows.
module beam_search_topk_selector import bsts_pkg::*; #(
   parameter int MAX_BEAMS = 4,
   parameter int TOKEN_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // log_prob, beam_index, token_index, zero pad
   input  logic        req_tlast,   // step_end
   input  logic        req_tuser,   // new_search
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // slot, source_beam, token, score,
                                    // is_end_token, slot_done, every_done, zero pad
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int KW = $clog2(MAX_BEAMS + 1);
   localparam int BW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
   localparam int TOK_W = (TOKEN_BITS < 16) ? TOKEN_BITS : 16;

   // Configuration registers.
   logic [4:0]  beams_ff;
   logic [31:0] thr_ff;
   logic [15:0] eos_a_ff, eos_b_ff;
   logic [1:0]  eos_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beams_ff <= 5'd4;
         thr_ff <= Q_MIN;
         eos_a_ff <= '0;
         eos_b_ff <= '0;
         eos_en_ff <= 2'b01;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BEAMS: beams_ff <= csr_wdata[4:0];
            REG_THRESH: thr_ff <= csr_wdata;
            REG_EOS_A: eos_a_ff <= csr_wdata[15:0];
            REG_EOS_B: eos_b_ff <= csr_wdata[15:0];
            REG_EOS_EN: eos_en_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Active beam count, clamped to 1..MAX_BEAMS.
   logic [KW-1:0] k;
   always_comb begin
      if (beams_ff == 5'd0) begin
         k = KW'(1);
      end else if (beams_ff > 5'(MAX_BEAMS)) begin
         k = KW'(MAX_BEAMS);
      end else begin
         k = KW'(beams_ff);
      end
   end

   // Input beat fields.
   logic [31:0] lp;
   logic [3:0]  beam;
   logic [15:0] tok;
   logic        acc, ns;
   logic        end_pend_ff, end_pend_in;

   assign lp = req_tdata[31:0];
   assign beam = req_tdata[35:32];
   always_comb begin
      tok = '0;
      tok[TOK_W-1:0] = req_tdata[36 +: TOK_W];
   end
   assign req_tready = !end_pend_ff;
   assign acc = req_tvalid && req_tready;
   assign ns = acc && req_tuser;

   // Beam state, seen after a new-search restart of this beat.
   logic [31:0] bs_ff [MAX_BEAMS];
   logic        fin_ff [MAX_BEAMS];
   logic [31:0] bv_score [MAX_BEAMS];
   logic        bv_fin [MAX_BEAMS];

   always_comb begin
      for (int i = 0; i < MAX_BEAMS; i++) begin
         if (ns) begin
            bv_score[i] = (i == 0) ? 32'd0 : Q_MIN;
            bv_fin[i] = 1'b0;
         end else begin
            bv_score[i] = bs_ff[i];
            bv_fin[i] = fin_ff[i];
         end
      end
   end

   // Score of the new candidate, with minus infinity and saturation.
   logic        beam_ok;
   logic [31:0] bsel;
   logic signed [32:0] s33;
   logic [31:0] sum;
   logic        ins;

   always_comb begin
      beam_ok = ({1'b0, beam} < 5'(k)) && !bv_fin[beam[BW-1:0]];
      bsel = bv_score[beam[BW-1:0]];
      s33 = $signed({bsel[31], bsel}) + $signed({lp[31], lp});
      if (bsel == Q_MIN || lp == Q_MIN) begin
         sum = Q_MIN;
      end else if (s33 > $signed({1'b0, Q_MAX})) begin
         sum = Q_MAX;
      end else if (s33 < $signed({1'b1, Q_MIN_P1})) begin
         sum = Q_MIN_P1;
      end else begin
         sum = s33[31:0];
      end
      ins = acc && beam_ok && ($signed(sum) >= $signed(thr_ff));
   end

   // Hand-off to the drain, now or once the drain frees.
   logic drain_free, snap;
   assign snap = drain_free && (end_pend_ff || (acc && req_tlast));
   assign end_pend_in = end_pend_ff ? !drain_free : (acc && req_tlast && !drain_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         end_pend_ff <= 1'b0;
      end else begin
         end_pend_ff <= end_pend_in;
      end
   end

   // Sorted candidate chain, best in cell 0.
   cell_ctl_type ctl;
   cand_type     new_cand;
   cand_type     cell_cur [MAX_BEAMS];
   cand_type     cell_nxt [MAX_BEAMS];
   logic [MAX_BEAMS-1:0] keep;

   assign ctl.take = acc;
   assign ctl.ins = ins;
   assign ctl.pre_clr = ns;
   assign ctl.post_clr = snap;
   assign new_cand.vld = 1'b1;
   assign new_cand.score = sum;
   assign new_cand.beam = beam;
   assign new_cand.tok = tok;

   for (genvar g = 0; g < MAX_BEAMS; g++) begin : g_cell
      logic     lk;
      cand_type lc;
      if (g == 0) begin : g_head
         assign lk = 1'b1;
         assign lc = '0;
      end else begin : g_body
         assign lk = keep[g - 1];
         assign lc = cell_cur[g - 1];
      end
      bsts_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (KW'(g) < k),
         .ctl       (ctl),
         .new_cand  (new_cand),
         .left_keep (lk),
         .left_cand (lc),
         .keep      (keep[g]),
         .cur       (cell_cur[g]),
         .nxt       (cell_nxt[g])
      );
   end

   // Results of the step and the beam state they leave behind.
   out_ent_type ent [MAX_BEAMS];
   logic        all_fin, all_new;

   always_comb begin
      cand_type c;
      all_fin = 1'b1;
      for (int i = 0; i < MAX_BEAMS; i++) begin
         if (KW'(i) < k && !bv_fin[i]) begin
            all_fin = 1'b0;
         end
      end
      all_new = 1'b1;
      for (int i = 0; i < MAX_BEAMS; i++) begin
         c = end_pend_ff ? cell_cur[i] : cell_nxt[i];
         if (all_fin) begin
            ent[i].src = 4'(i);
            ent[i].tok = '0;
            ent[i].score = bv_score[i];
            ent[i].eos = 1'b0;
            ent[i].done = 1'b1;
         end else if (c.vld) begin
            ent[i].src = c.beam;
            ent[i].tok = c.tok;
            ent[i].score = c.score;
            ent[i].eos = (eos_en_ff[0] && c.tok == eos_a_ff) ||
                         (eos_en_ff[1] && c.tok == eos_b_ff);
            ent[i].done = ent[i].eos;
         end else begin
            ent[i].src = '0;
            ent[i].tok = '0;
            ent[i].score = Q_MIN;
            ent[i].eos = 1'b0;
            ent[i].done = 1'b1;
         end
         if (KW'(i) < k && !ent[i].done) begin
            all_new = 1'b0;
         end
      end
   end

   // Beam state update: restart, then the step's new beams.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BEAMS; i++) begin
            bs_ff[i] <= (i == 0) ? 32'd0 : Q_MIN;
            fin_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < MAX_BEAMS; i++) begin
            if (snap && !all_fin && KW'(i) < k) begin
               bs_ff[i] <= ent[i].score;
               fin_ff[i] <= ent[i].done;
            end else begin
               bs_ff[i] <= bv_score[i];
               fin_ff[i] <= bv_fin[i];
            end
         end
      end
   end

   // Output drain and result packing.
   out_ent_type head;
   logic [3:0]  slot;
   logic        every_done;

   bsts_drain #(
      .MAX_BEAMS (MAX_BEAMS),
      .KW        (KW)
   ) u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (snap),
      .load_cnt   (k),
      .load_all   (all_fin || all_new),
      .load_ent   (ent),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .head       (head),
      .slot       (slot),
      .every_done (every_done),
      .free       (drain_free)
   );

   assign rsp_tdata = {5'd0, every_done, head.done, head.eos, head.score, head.tok,
                       head.src, slot};

endmodule

// ===== design/bsts_checker.sv =====
// Port-level checks of the beam search top-k selector result stream,
// attached to the top level by the bind at the end. No package needed.
module bsts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Within a step, slots follow each other and every_done stays put.
   a_slot_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid &&
      rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1 && rsp_tdata[58] == $past(rsp_tdata[58]))
      else $error("slot sequence or every_done broken within a step");

   // A new step starts at slot 0.
   a_slot_first: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tdata[3:0] == 4'd0)
      else $error("step did not start at slot 0");

   // An end token always finishes its slot.
   a_eos_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[56] |-> rsp_tdata[57])
      else $error("end token without slot_done");

endmodule

bind beam_search_topk_selector bsts_checker u_bsts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
